/* src/deadlock_avoidance_checker_unit_defines.svh */
`ifndef DEADLOCK_AVOIDANCE_CHECKER_UNIT_DEFINES_SVH
`define DEADLOCK_AVOIDANCE_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, reset masked.
`define DAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masked.
`define DAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/dac_pkg.sv */
`default_nettype none

package dac_pkg;

	localparam int MAX_PROCS_DEF  = 16;
	localparam int MAX_RES_DEF    = 16;
	localparam int COUNT_BITS_DEF = 16;

	localparam int CMD_W     = 3;
	localparam int IDX_W     = 4;
	localparam int VALUE_W   = 16;
	localparam int STATUS_W  = 3;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_RES   = 1'b1;

	localparam logic [CFG_W-1:0] NUM_PROCS_RST = 5'd5;
	localparam logic [CFG_W-1:0] NUM_RES_RST   = 5'd3;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_ALLOC = 3'd0,
		CMD_LOAD_MAX   = 3'd1,
		CMD_LOAD_AVAIL = 3'd2,
		CMD_REQ_ELEM   = 3'd3,
		CMD_CHECK      = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_LOADED  = 3'd0,
		ST_SAFE    = 3'd1,
		ST_UNSAFE  = 3'd2,
		ST_GRANTED = 3'd3,
		ST_DENIED  = 3'd4,
		ST_EXCEEDS = 3'd5,
		ST_WAIT    = 3'd6
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    latch;
		logic    wr_alloc;
		logic    wr_need;
		logic    wr_avail;
		logic    wr_req;
		logic    rd_walk;
		logic    trial;
		logic    rollback;
		logic    walk_init;
		logic    walk_eval;
		logic    emit;
		logic    emit_seq;
		logic    k_clr;
		logic    k_inc;
		status_t emit_status;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic slot_free;
		logic last_el;
		logic p_in_use;
		logic req_bad;
		logic req_need_fail;
		logic walk_pass_end;
		logic walk_all_done;
		logic walk_found;
		logic seq_end;
	} dp_sts_t;

endpackage

`default_nettype wire

/* src/dac_dp.sv */
`default_nettype none

`include "deadlock_avoidance_checker_unit_defines.svh"

module dac_dp #(
	parameter int MAX_PROCS  = dac_pkg::MAX_PROCS_DEF,
	parameter int MAX_RES    = dac_pkg::MAX_RES_DEF,
	parameter int COUNT_BITS = dac_pkg::COUNT_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dac_pkg::CFG_W-1:0]      cfg_wdata,
	input  wire logic [dac_pkg::IDX_W-1:0]      proc,
	input  wire logic [dac_pkg::IDX_W-1:0]      res,
	input  wire logic [dac_pkg::VALUE_W-1:0]    value,
	input  wire logic                           req_last,
	input  wire dac_pkg::dp_cmd_t               dp_cmd,
	output dac_pkg::dp_sts_t                    sts,
	input  wire logic                           out_stall,
	output logic                                out_valid,
	output logic [dac_pkg::STATUS_W-1:0]        status,
	output logic [dac_pkg::IDX_W-1:0]           seq_proc,
	output logic                                last
);
	import dac_pkg::*;

	localparam int PB  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int RB  = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
	localparam int NPW = $clog2(MAX_PROCS + 1);
	localparam int MW  = $clog2(MAX_RES + 1);
	localparam int CB  = COUNT_BITS;
	localparam int NW  = COUNT_BITS + 1;
	localparam int WW  = COUNT_BITS + PB + 1;

	// config
	logic [CFG_W-1:0] num_procs_q, num_res_q;
	logic [NPW-1:0]   n;
	logic [MW-1:0]    m;

	// latched item
	logic [IDX_W-1:0] proc_q, res_q;
	logic [CB-1:0]    val_q;
	logic             last_q;

	// tables
	logic [MAX_RES*CB-1:0] alloc_mem [MAX_PROCS];
	logic [MAX_RES*NW-1:0] need_mem  [MAX_PROCS];
	logic [MAX_RES*CB-1:0] alloc_rd_q;
	logic [MAX_RES*NW-1:0] need_rd_q;
	logic [PB-1:0]         raddr, waddr;

	logic [CB-1:0] avail_q [MAX_RES];
	logic [CB-1:0] req_q   [MAX_RES];

	// walk state
	logic [WW-1:0]      work_q [MAX_RES];
	logic [MAX_PROCS-1:0] done_q;
	logic [PB-1:0]      seq_q [MAX_PROCS];
	logic [NPW-1:0]     cnt_q;
	logic [PB-1:0]      i_q;
	logic               found_q;
	logic [PB-1:0]      k_q;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    seq_proc_q;
	logic                last_q_out;

	// lane logic
	logic [CB-1:0]      a_el   [MAX_RES];
	logic [NW-1:0]      n_el   [MAX_RES];
	logic [MAX_RES-1:0] lane_on;
	logic [MAX_RES-1:0] alloc_we, need_we;
	logic [CB-1:0]      alloc_wd [MAX_RES];
	logic [NW-1:0]      need_wd  [MAX_RES];
	logic [RB-1:0]      rl;
	logic               pin, rin, fit, hit, req_bad, req_need_fail;
	logic [NPW-1:0]     cnt_next;

	always_comb begin
		if (num_procs_q == '0) begin
			n = NPW'(1);
		end else if (int'(num_procs_q) > MAX_PROCS) begin
			n = NPW'(MAX_PROCS);
		end else begin
			n = NPW'(num_procs_q);
		end
		if (num_res_q == '0) begin
			m = MW'(1);
		end else if (int'(num_res_q) > MAX_RES) begin
			m = MW'(MAX_RES);
		end else begin
			m = MW'(num_res_q);
		end
	end

	assign pin   = int'(proc_q) < MAX_PROCS;
	assign rin   = int'(res_q) < MAX_RES;
	assign rl    = RB'(res_q);
	assign raddr = dp_cmd.rd_walk ? i_q : PB'(proc_q);
	assign waddr = PB'(proc_q);

	always_comb begin
		fit           = 1'b1;
		req_bad       = 1'b0;
		req_need_fail = 1'b0;
		for (int j = 0; j < MAX_RES; j++) begin
			a_el[j]    = alloc_rd_q[j*CB +: CB];
			n_el[j]    = need_rd_q[j*NW +: NW];
			lane_on[j] = j < int'(m);
			// positive need above work blocks the process
			if (lane_on[j] && !n_el[j][NW-1] && (|n_el[j][CB-1:0])
				&& (WW'(n_el[j][CB-1:0]) > work_q[j])) begin
				fit = 1'b0;
			end
		end
		// lowest failing element decides; need test before availability
		for (int j = MAX_RES - 1; j >= 0; j--) begin
			if (lane_on[j] && (n_el[j][NW-1] || (req_q[j] > n_el[j][CB-1:0])
				|| (req_q[j] > avail_q[j]))) begin
				req_bad       = 1'b1;
				req_need_fail = n_el[j][NW-1] || (req_q[j] > n_el[j][CB-1:0]);
			end
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_RES; j++) begin
			alloc_we[j] = 1'b0;
			need_we[j]  = 1'b0;
			alloc_wd[j] = val_q;
			need_wd[j]  = {1'b0, val_q} - {1'b0, a_el[j]};
			priority if (dp_cmd.wr_alloc) begin
				alloc_we[j] = (j == int'(rl)) && pin && rin;
			end else if (dp_cmd.wr_need) begin
				need_we[j] = (j == int'(rl)) && pin && rin;
			end else if (dp_cmd.trial) begin
				alloc_we[j] = lane_on[j];
				need_we[j]  = lane_on[j];
				alloc_wd[j] = a_el[j] + req_q[j];
				need_wd[j]  = n_el[j] - {1'b0, req_q[j]};
			end else if (dp_cmd.rollback) begin
				alloc_we[j] = lane_on[j];
				need_we[j]  = lane_on[j];
				alloc_wd[j] = a_el[j] - req_q[j];
				need_wd[j]  = n_el[j] + {1'b0, req_q[j]};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_RES; j++) begin
			if (alloc_we[j]) begin
				alloc_mem[waddr][j*CB +: CB] <= alloc_wd[j];
			end
			if (need_we[j]) begin
				need_mem[waddr][j*NW +: NW] <= need_wd[j];
			end
		end
		alloc_rd_q <= alloc_mem[raddr];
		need_rd_q  <= need_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_procs_q <= NUM_PROCS_RST;
			num_res_q   <= NUM_RES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_PROCS: num_procs_q <= cfg_wdata;
				CFG_NUM_RES:   num_res_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.latch) begin
			proc_q <= proc;
			res_q  <= res;
			val_q  <= CB'(value);
			last_q <= req_last;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_RES; j++) begin
			if (dp_cmd.wr_avail && rin && (j == int'(rl))) begin
				avail_q[j] <= val_q;
			end else if (dp_cmd.trial && lane_on[j]) begin
				avail_q[j] <= avail_q[j] - req_q[j];
			end else if (dp_cmd.rollback && lane_on[j]) begin
				avail_q[j] <= avail_q[j] + req_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_RES; j++) begin
				req_q[j] <= '0;
			end
		end else if (dp_cmd.wr_req && rin) begin
			req_q[rl] <= val_q;
		end
	end

	// safety walk
	assign hit      = !done_q[i_q] && fit;
	assign cnt_next = cnt_q + NPW'(hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			cnt_q   <= '0;
			i_q     <= '0;
			found_q <= 1'b0;
		end else if (dp_cmd.walk_init) begin
			done_q  <= '0;
			cnt_q   <= '0;
			i_q     <= '0;
			found_q <= 1'b0;
		end else if (dp_cmd.walk_eval) begin
			if (hit) begin
				done_q[i_q] <= 1'b1;
			end
			cnt_q <= cnt_next;
			if (sts.walk_pass_end) begin
				i_q     <= '0;
				found_q <= 1'b0;
			end else begin
				i_q     <= i_q + PB'(1);
				found_q <= found_q | hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.walk_init) begin
			for (int j = 0; j < MAX_RES; j++) begin
				work_q[j] <= WW'(avail_q[j]);
			end
		end else if (dp_cmd.walk_eval && hit) begin
			for (int j = 0; j < MAX_RES; j++) begin
				work_q[j] <= work_q[j] + WW'(a_el[j]);
			end
			seq_q[cnt_q[PB-1:0]] <= i_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (dp_cmd.k_clr) begin
			k_q <= '0;
		end else if (dp_cmd.k_inc) begin
			k_q <= k_q + PB'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.emit) begin
			status_q <= dp_cmd.emit_status;
			if (dp_cmd.emit_seq) begin
				seq_proc_q <= IDX_W'(seq_q[k_q]);
				last_q_out <= sts.seq_end;
			end else begin
				seq_proc_q <= '0;
				last_q_out <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign seq_proc  = seq_proc_q;
	assign last      = last_q_out;

	assign sts.slot_free     = !out_valid_q || !out_stall;
	assign sts.last_el       = last_q;
	assign sts.p_in_use      = int'(proc_q) < int'(n);
	assign sts.req_bad       = req_bad;
	assign sts.req_need_fail = req_need_fail;
	assign sts.walk_pass_end = i_q == PB'(n - NPW'(1));
	assign sts.walk_all_done = cnt_next == n;
	assign sts.walk_found    = found_q | hit;
	assign sts.seq_end       = k_q == PB'(n - NPW'(1));

	`DAC_ASSERT_NOW(a_emit_slot, clk, arst_n, dp_cmd.emit, sts.slot_free, "result issued into a held output register")
	`DAC_ASSERT_NOW(a_trial_ok, clk, arst_n, dp_cmd.trial, !req_bad, "trial allocation of a failing request")
	`DAC_ASSERT_NOW(a_seq_full, clk, arst_n, dp_cmd.emit && dp_cmd.emit_seq, cnt_q == n, "safe sequence emitted before it is complete")

endmodule

`default_nettype wire

/* src/dac_ctrl.sv */
`default_nettype none

`include "deadlock_avoidance_checker_unit_defines.svh"

module dac_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [dac_pkg::CMD_W-1:0]  cmd,
	output logic                            in_stall,
	output dac_pkg::dp_cmd_t                dp_cmd,
	input  wire dac_pkg::dp_sts_t           sts
);
	import dac_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE     = 15'b000000000000001,
		S_LD_ALLOC = 15'b000000000000010,
		S_LD_MAX_RD= 15'b000000000000100,
		S_LD_MAX_WR= 15'b000000000001000,
		S_LD_AVAIL = 15'b000000000010000,
		S_REQ_BUF  = 15'b000000000100000,
		S_REQ_EVAL = 15'b000000001000000,
		S_TRIAL    = 15'b000000010000000,
		S_SAFE_INIT= 15'b000000100000000,
		S_SAFE_RD  = 15'b000001000000000,
		S_SAFE_EV  = 15'b000010000000000,
		S_ROLL_RD  = 15'b000100000000000,
		S_ROLL_WR  = 15'b001000000000000,
		S_EMIT_ONE = 15'b010000000000000,
		S_EMIT_SEQ = 15'b100000000000000
	} state_t;

	state_t  state_q, state_d;
	status_t code_q, code_d;
	logic    req_mode_q, req_mode_d;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d            = state_q;
		code_d             = code_q;
		req_mode_d         = req_mode_q;
		dp_cmd             = '0;
		dp_cmd.emit_status = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dp_cmd.latch = 1'b1;
					code_d       = ST_LOADED;
					unique case (cmd)
						CMD_LOAD_ALLOC: state_d = S_LD_ALLOC;
						CMD_LOAD_MAX:   state_d = S_LD_MAX_RD;
						CMD_LOAD_AVAIL: state_d = S_LD_AVAIL;
						CMD_REQ_ELEM:   state_d = S_REQ_BUF;
						CMD_CHECK: begin
							req_mode_d = 1'b0;
							state_d    = S_SAFE_INIT;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_LD_ALLOC: begin
				dp_cmd.wr_alloc = 1'b1;
				state_d         = S_EMIT_ONE;
			end
			S_LD_MAX_RD: state_d = S_LD_MAX_WR;
			S_LD_MAX_WR: begin
				dp_cmd.wr_need = 1'b1;
				state_d        = S_EMIT_ONE;
			end
			S_LD_AVAIL: begin
				dp_cmd.wr_avail = 1'b1;
				state_d         = S_EMIT_ONE;
			end
			S_REQ_BUF: begin
				dp_cmd.wr_req = 1'b1;
				if (!sts.last_el) begin
					state_d = S_EMIT_ONE;
				end else if (!sts.p_in_use) begin
					code_d  = ST_EXCEEDS;
					state_d = S_EMIT_ONE;
				end else begin
					state_d = S_REQ_EVAL;
				end
			end
			S_REQ_EVAL: begin
				if (sts.req_bad) begin
					code_d  = sts.req_need_fail ? ST_EXCEEDS : ST_WAIT;
					state_d = S_EMIT_ONE;
				end else begin
					state_d = S_TRIAL;
				end
			end
			S_TRIAL: begin
				dp_cmd.trial = 1'b1;
				req_mode_d   = 1'b1;
				state_d      = S_SAFE_INIT;
			end
			S_SAFE_INIT: begin
				dp_cmd.walk_init = 1'b1;
				state_d          = S_SAFE_RD;
			end
			S_SAFE_RD: begin
				dp_cmd.rd_walk = 1'b1;
				state_d        = S_SAFE_EV;
			end
			S_SAFE_EV: begin
				dp_cmd.walk_eval = 1'b1;
				if (sts.walk_all_done) begin
					dp_cmd.k_clr = 1'b1;
					state_d      = S_EMIT_SEQ;
				end else if (sts.walk_pass_end && !sts.walk_found) begin
					code_d  = req_mode_q ? ST_DENIED : ST_UNSAFE;
					state_d = req_mode_q ? S_ROLL_RD : S_EMIT_ONE;
				end else begin
					state_d = S_SAFE_RD;
				end
			end
			S_ROLL_RD: state_d = S_ROLL_WR;
			S_ROLL_WR: begin
				dp_cmd.rollback = 1'b1;
				state_d         = S_EMIT_ONE;
			end
			S_EMIT_ONE: begin
				if (sts.slot_free) begin
					dp_cmd.emit = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_EMIT_SEQ: begin
				dp_cmd.emit_status = req_mode_q ? ST_GRANTED : ST_SAFE;
				if (sts.slot_free) begin
					dp_cmd.emit     = 1'b1;
					dp_cmd.emit_seq = 1'b1;
					if (sts.seq_end) begin
						state_d = S_IDLE;
					end else begin
						dp_cmd.k_inc = 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			code_q     <= ST_LOADED;
			req_mode_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			code_q     <= code_d;
			req_mode_q <= req_mode_d;
		end
	end

	`DAC_ASSERT_NEXT(a_walk_done, clk, arst_n, (state_q == S_SAFE_EV) && sts.walk_all_done, state_q == S_EMIT_SEQ, "finished walk did not start the sequence")
	`DAC_ASSERT_NEXT(a_out_of_use, clk, arst_n, (state_q == S_REQ_BUF) && sts.last_el && !sts.p_in_use, (state_q == S_EMIT_ONE) && (code_q == ST_EXCEEDS), "request of an idle process not refused")
	`DAC_ASSERT_NOW(a_state_onehot, clk, arst_n, 1'b1, $onehot(state_q), "controller state not one-hot")

endmodule

`default_nettype wire

/* src/deadlock_avoidance_checker_unit.sv */
// Loads: one result per transfer in, after the table write (loading max reads the row first).
// Safety check: each process visit reads its rows, then evaluates them; up to num_procs passes
// of num_procs visits, then, if safe, n results at one per cycle when out_stall is low.
// Requests add the element check, the trial write and, on failure, a rollback read and write.
// One item at a time; the output register lets the next item start while a result waits.
// arst_n clears control state, num_procs to 5, num_res to 3 and the request buffer to zero.
`default_nettype none

module deadlock_avoidance_checker_unit #(
	parameter int MAX_PROCS  = dac_pkg::MAX_PROCS_DEF,
	parameter int MAX_RES    = dac_pkg::MAX_RES_DEF,
	parameter int COUNT_BITS = dac_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration writes, only while idle
	input  wire logic                          cfg_we,
	input  wire logic [dac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dac_pkg::CFG_W-1:0]     cfg_wdata,
	// command channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [dac_pkg::CMD_W-1:0]     cmd,
	input  wire logic [dac_pkg::IDX_W-1:0]     proc,
	input  wire logic [dac_pkg::IDX_W-1:0]     res,
	input  wire logic [dac_pkg::VALUE_W-1:0]   value,
	input  wire logic                          req_last,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [dac_pkg::STATUS_W-1:0]       status,
	output logic [dac_pkg::IDX_W-1:0]          seq_proc,
	output logic                               last
);
	import dac_pkg::*;

	// The controller sequences loads, request checks, the safety walk and
	// result transfers; the datapath owns the tables and the walk registers.
	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	dac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.dp_cmd   (dp_cmd),
		.sts      (dp_sts)
	);

	// Allocation and need tables are row-per-process memories so that one
	// read compares every resource of a process in parallel against work.
	dac_dp #(
		.MAX_PROCS  (MAX_PROCS),
		.MAX_RES    (MAX_RES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.proc      (proc),
		.res       (res),
		.value     (value),
		.req_last  (req_last),
		.dp_cmd    (dp_cmd),
		.sts       (dp_sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.status    (status),
		.seq_proc  (seq_proc),
		.last      (last)
	);

endmodule

`default_nettype wire

/* sim/deadlock_avoidance_checker_unit_test.sv */
`default_nettype none

// Banker's engine testbench: directed and random command streams, a local
// predictor of the allocation/need/available tables, and an in-order compare
// of every result transfer.
module deadlock_avoidance_checker_unit_test;
	import dac_pkg::*;

	localparam int NP = MAX_PROCS_DEF;
	localparam int NR = MAX_RES_DEF;

	// results expected back, oldest first
	typedef struct packed {
		logic [STATUS_W-1:0] st;
		logic [IDX_W-1:0]    sp;
		logic                lst;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] cmd = '0;
	logic [IDX_W-1:0] proc = '0;
	logic [IDX_W-1:0] res = '0;
	logic [VALUE_W-1:0] value = '0;
	logic req_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0] seq_proc;
	logic last;

	deadlock_avoidance_checker_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .proc(proc), .res(res), .value(value), .req_last(req_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .seq_proc(seq_proc), .last(last)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [4:0] procs_reg, res_reg;
	logic [15:0] alloc_tbl [NP*NR];
	longint need_tbl [NP*NR];
	logic [15:0] avail_vec [NR];
	logic [15:0] req_buf [NR];
	// written markers: random stimulus never reads an unwritten entry
	bit alloc_wr [NP*NR];
	bit need_wr [NP*NR];
	bit avail_wr [NR];

	outcome_t expected_q [$];
	int errors = 0;
	bit quiet_in = 1'b0;   // no sender gaps
	bit quiet_out = 1'b0;  // no receiver stalls
	bit hold_off = 1'b0;   // long receiver hold-off

	function automatic int procs_used();
		if (procs_reg < 1) return 1;
		if (procs_reg > NP) return NP;
		return procs_reg;
	endfunction

	function automatic int res_used();
		if (res_reg < 1) return 1;
		if (res_reg > NR) return NR;
		return res_reg;
	endfunction

	function automatic void push(status_t s, int sp, bit l);
		outcome_t o;
		o.st = s;
		o.sp = sp[IDX_W-1:0];
		o.lst = l;
		expected_q.push_back(o);
	endfunction

	// Safety walk: index order, pass after pass, work updated within the pass.
	function automatic void run_walk(status_t ok_st, status_t bad_st, output bit safe);
		longint work [NR];
		bit done_f [NP];
		int order [NP];
		int n, m, cnt;
		bit found, fits;
		n = procs_used();
		m = res_used();
		cnt = 0;
		for (int j = 0; j < NR; j++) work[j] = (j < m) ? avail_vec[j] : 0;
		for (int i = 0; i < NP; i++) done_f[i] = 0;
		safe = 1;
		while (cnt < n && safe) begin
			found = 0;
			for (int i = 0; i < n; i++) begin
				if (!done_f[i]) begin
					fits = 1;
					for (int j = 0; j < m; j++)
						if (need_tbl[i*NR+j] > 0 && need_tbl[i*NR+j] > work[j]) fits = 0;
					if (fits) begin
						for (int j = 0; j < m; j++) work[j] += alloc_tbl[i*NR+j];
						order[cnt] = i;
						cnt++;
						done_f[i] = 1;
						found = 1;
					end
				end
			end
			if (!found) safe = 0;
		end
		if (!safe) push(bad_st, 0, 1);
		else for (int k = 0; k < n; k++) push(ok_st, order[k], k == n - 1);
	endfunction

	function automatic void predict_request(int p);
		int m;
		bit safe;
		m = res_used();
		if (p >= procs_used()) begin
			push(ST_EXCEEDS, 0, 1);
			return;
		end
		for (int j = 0; j < m; j++) begin
			if (need_tbl[p*NR+j] < 0 || req_buf[j] > need_tbl[p*NR+j]) begin
				push(ST_EXCEEDS, 0, 1);
				return;
			end
			if (req_buf[j] > avail_vec[j]) begin
				push(ST_WAIT, 0, 1);
				return;
			end
		end
		for (int j = 0; j < m; j++) begin
			avail_vec[j] -= req_buf[j];
			alloc_tbl[p*NR+j] += req_buf[j];
			need_tbl[p*NR+j] -= req_buf[j];
		end
		run_walk(ST_GRANTED, ST_DENIED, safe);
		if (!safe)
			for (int j = 0; j < m; j++) begin
				avail_vec[j] += req_buf[j];
				alloc_tbl[p*NR+j] -= req_buf[j];
				need_tbl[p*NR+j] += req_buf[j];
			end
	endfunction

	function automatic void predict_item(logic [2:0] c, int p, int r, logic [15:0] v, bit rl);
		bit safe;
		case (c)
			CMD_LOAD_ALLOC: begin
				alloc_tbl[p*NR+r] = v;
				alloc_wr[p*NR+r] = 1;
				push(ST_LOADED, 0, 1);
			end
			CMD_LOAD_MAX: begin
				need_tbl[p*NR+r] = longint'(v) - longint'(alloc_tbl[p*NR+r]);
				need_wr[p*NR+r] = 1;
				push(ST_LOADED, 0, 1);
			end
			CMD_LOAD_AVAIL: begin
				avail_vec[r] = v;
				avail_wr[r] = 1;
				push(ST_LOADED, 0, 1);
			end
			CMD_REQ_ELEM: begin
				req_buf[r] = v;
				if (!rl) push(ST_LOADED, 0, 1);
				else predict_request(p);
			end
			CMD_CHECK: run_walk(ST_SAFE, ST_UNSAFE, safe);
			default: ;
		endcase
	endfunction

	// one transfer in; predicts on acceptance. in_valid stays high into the
	// next item and drops only in a sender gap or in drain.
	task automatic send_item(int c, int p, int r, int v, int rl = 0);
		while (!quiet_in && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c[2:0];
		proc <= p[3:0];
		res <= r[3:0];
		value <= v[15:0];
		req_last <= rl[0];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_item(c[2:0], int'(p[3:0]), int'(r[3:0]), v[15:0], rl[0]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [4:0] d);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_NUM_PROCS) procs_reg = d;
		else res_reg = d;
	endtask

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) report_mismatch("unexpected result, status", status, -1);
			else begin
				e = expected_q.pop_front();
				if (status !== e.st) report_mismatch("status", status, e.st);
				if (seq_proc !== e.sp) report_mismatch("seq_proc", seq_proc, e.sp);
				if (last !== e.lst) report_mismatch("last", last, e.lst);
			end
		end
	end

	// receiver stalls, random or a long hold-off
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= !quiet_out && ($urandom_range(99) < 7);
	end

	// writes every used entry not loaded yet so later walks read defined state
	task automatic fill_tables(int maxv);
		for (int p = 0; p < procs_used(); p++)
			for (int r = 0; r < res_used(); r++) begin
				if (!alloc_wr[p*NR+r])
					send_item(CMD_LOAD_ALLOC, p, r, $urandom_range(maxv));
				if (!need_wr[p*NR+r])
					send_item(CMD_LOAD_MAX, p, r, $urandom_range(2*maxv));
			end
		for (int r = 0; r < res_used(); r++)
			if (!avail_wr[r]) send_item(CMD_LOAD_AVAIL, 0, r, $urandom_range(2*maxv));
	endtask

	function automatic bit tables_ready();
		for (int p = 0; p < procs_used(); p++)
			for (int r = 0; r < res_used(); r++)
				if (!alloc_wr[p*NR+r] || !need_wr[p*NR+r]) return 0;
		for (int r = 0; r < res_used(); r++) if (!avail_wr[r]) return 0;
		return 1;
	endfunction

	// classic textbook case plus field extremes; loaded, safe, granted, exceeds and wait results
	task automatic test_directed();
		int al [5][3] = '{'{0,1,0},'{2,0,0},'{3,0,2},'{2,1,1},'{0,0,2}};
		int mx [5][3] = '{'{7,5,3},'{3,2,2},'{9,0,2},'{2,2,2},'{4,3,3}};
		int av [3] = '{3,3,2};
		for (int p = 0; p < 5; p++)
			for (int r = 0; r < 3; r++) begin
				send_item(CMD_LOAD_ALLOC, p, r, al[p][r]);
				send_item(CMD_LOAD_MAX, p, r, mx[p][r]);
			end
		for (int r = 0; r < 3; r++) send_item(CMD_LOAD_AVAIL, 0, r, av[r]);
		send_item(CMD_CHECK, 0, 0, 0, 0);
		// granted request
		send_item(CMD_REQ_ELEM, 1, 0, 1, 0);
		send_item(CMD_REQ_ELEM, 1, 1, 0, 0);
		send_item(CMD_REQ_ELEM, 1, 2, 2, 1);
		// exceeds need, must wait, outside processes in use
		send_item(CMD_REQ_ELEM, 4, 2, 16'hFFFF, 1);
		send_item(CMD_REQ_ELEM, 0, 0, 0, 0);
		send_item(CMD_REQ_ELEM, 0, 1, 0, 0);
		send_item(CMD_REQ_ELEM, 0, 2, 0, 0);
		send_item(CMD_REQ_ELEM, 4, 0, 4, 1);
		send_item(CMD_REQ_ELEM, 15, 0, 0, 1);
		// unused commands and extremes
		send_item(3'd5, 15, 15, 16'hFFFF, 1);
		send_item(3'd7, 0, 0, 0, 0);
		send_item(3'd6, 0, 0, 0, 0);
		send_item(CMD_LOAD_ALLOC, 15, 15, 16'hFFFF, 1);
		send_item(CMD_LOAD_MAX, 15, 15, 16'h0000, 0);  // negative need
		send_item(CMD_LOAD_AVAIL, 0, 15, 16'hFFFF, 0);
		// request of process 4 that takes the last unit of res 0 (avail 1), then a check
		send_item(CMD_LOAD_AVAIL, 0, 0, 1, 0);
		send_item(CMD_REQ_ELEM, 4, 0, 1, 0);
		send_item(CMD_REQ_ELEM, 4, 2, 0, 1);
		send_item(CMD_CHECK, 0, 0, 0, 0);
	endtask

	task automatic test_config_extremes();
		write_cfg(CFG_NUM_PROCS, 5'd1);
		write_cfg(CFG_NUM_RES, 5'd1);
		send_item(CMD_CHECK, 0, 0, 0, 0);
		write_cfg(CFG_NUM_PROCS, 5'd0);  // clamps to one
		write_cfg(CFG_NUM_RES, 5'd0);    // clamps to one
		send_item(CMD_CHECK, 0, 0, 0, 0);
		write_cfg(CFG_NUM_PROCS, 5'd31); // clamps to all
		write_cfg(CFG_NUM_RES, 5'd1);
		fill_tables(3);
		send_item(CMD_CHECK, 0, 0, 0, 0);
	endtask

	// mostly well-formed requests and checks on defined tables, some noise
	task automatic random_items(int count);
		int p, r, m, sel, maxv;
		maxv = 6;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(99);
			m = res_used();
			p = $urandom_range(procs_used() - 1);
			if (sel < 40) begin
				for (int j = 0; j < m; j++)
					send_item(CMD_REQ_ELEM, $urandom_range(15), j, $urandom_range(3), 0);
				send_item(CMD_REQ_ELEM, ($urandom_range(9) == 0) ? $urandom_range(15) : p,
					m - 1, $urandom_range(3), 1);
			end else if (sel < 60) send_item(CMD_CHECK, $urandom, $urandom, $urandom, $urandom);
			else if (sel < 70) begin
				r = $urandom_range(m - 1);
				send_item(CMD_LOAD_ALLOC, p, r, $urandom_range(maxv));
				send_item(CMD_LOAD_MAX, p, r, $urandom_range(2*maxv));
			end else if (sel < 80)
				send_item(CMD_LOAD_AVAIL, 0, $urandom_range(m - 1), $urandom_range(3*maxv));
			else if (sel < 85) send_item(5 + $urandom_range(2), $urandom, $urandom, $urandom, 1);
			else if (sel < 92) begin
				// loads at any index write defined entries, any value
				send_item(CMD_LOAD_ALLOC, $urandom, $urandom, $urandom, $urandom);
			end else if (sel < 96) send_item(CMD_LOAD_MAX, p, $urandom_range(m-1), $urandom);
			else send_item(CMD_REQ_ELEM, $urandom, $urandom, $urandom, 0);
		end
	endtask

	task automatic test_random();
		write_cfg(CFG_NUM_PROCS, 5'd5);
		write_cfg(CFG_NUM_RES, 5'd3);
		fill_tables(6);
		random_items(8);
		quiet_in = 1;
		quiet_out = 1;
		random_items(6);
		quiet_in = 0;
		quiet_out = 0;
		write_cfg(CFG_NUM_PROCS, 5'd3);
		write_cfg(CFG_NUM_RES, 5'd2);
		random_items(6);
	endtask

	// receiver holds off while the sender keeps offering; then a paused sender
	task automatic test_pressure();
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			repeat (6) send_item(CMD_CHECK, 0, 0, 0, 0);
		join
		drain();
		send_item(CMD_CHECK, 0, 0, 0, 0);
	endtask

	initial begin
		procs_reg = NUM_PROCS_RST;
		res_reg = NUM_RES_RST;
		for (int i = 0; i < NP*NR; i++) begin
			alloc_tbl[i] = 0;
			need_tbl[i] = 0;
			alloc_wr[i] = 0;
			need_wr[i] = 0;
		end
		for (int r = 0; r < NR; r++) begin
			avail_vec[r] = 0;
			req_buf[r] = 0;
			avail_wr[r] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random();
		test_pressure();
		drain();
		if (errors == 0) $display("deadlock_avoidance_checker_unit: match");
		else $display("deadlock_avoidance_checker_unit: mismatch");
		$finish;
	end

	initial begin
		#4000000;
		$display("deadlock_avoidance_checker_unit: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
